/* src/gmm_pkg.sv */
// Shared types and codes for the gossip membership merge block.
// No dependencies; every other file imports this package.
package gmm_pkg;

    localparam int KEY_W         = 32;
    localparam int GEN_W         = 64;
    localparam int STATUS_W      = 3;
    localparam int ENTRY_INDEX_W = 6;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 64;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_KEY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_GEN = 1'd1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LEARNED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DEAD    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REFUTED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_REVIVED = 3'd6;

    // Input function codes
    localparam logic FUNC_MERGE = 1'b0;
    localparam logic FUNC_INTRO = 1'b1;

    // Depth of the queue between the front and back parts
    localparam int JOB_Q_DEPTH = 2;
    localparam int JOB_Q_PW    = $clog2(JOB_Q_DEPTH);

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] member_key;
        logic             is_dead;
        logic [GEN_W-1:0] generation;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic                     view_changed;
        logic [ENTRY_INDEX_W-1:0] entry_index;
        logic                     entry_dead;
        logic [GEN_W-1:0]         entry_generation;
        logic [GEN_W-1:0]         own_generation;
    } t_out_item;

    // Classified item as it travels from front to back
    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] member_key;
        logic             is_dead;
        logic [GEN_W-1:0] generation;
        logic             is_self;
    } t_job;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [GEN_W-1:0] generation;
        logic             dead;
    } t_entry;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg;

endpackage

/* src/gossip_membership_merge_core.sv */
// Top level of the gossip membership merge block: front, job queue and back part.
// Depends on gmm_pkg, gmm_front, gmm_fifo and gmm_back.
//
// Each transaction names one member and either merges a gossip line or
// introduces a caller. A line about this node itself skips the table scan
// and goes straight to the merge step. Any other line, if the table is not
// empty, scans the membership table one entry per cycle through the single
// read port of the table memory, stopping at the first matching key. The
// back part starts a job only while the result register is free. A
// two-entry queue lets new transactions be taken while the back part
// works, and a result register holds the finished result until it is
// popped. No clearing pass runs after reset; table slots at or above the
// entry count are never read.
module gossip_membership_merge_core
    import gmm_pkg::*;
#(
    parameter int MAX_MEMBERS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  t_in_item              i_item,
    output logic                  o_empty,
    input  logic                  i_pop,
    output t_out_item             o_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg cfg;
    logic q_push;
    t_job q_in;
    logic q_valid;
    logic q_pop;
    t_job q_out;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    gmm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_push   (i_push),
        .i_item   (i_item),
        .o_q_push (q_push),
        .o_job    (q_in)
    );

    gmm_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_full  (o_full),
        .i_data  (q_in),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_out)
    );

    gmm_back #(
        .MAX_MEMBERS (MAX_MEMBERS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (q_valid),
        .o_job_pop   (q_pop),
        .i_job       (q_out),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_item      (o_item)
    );

endmodule

/* src/gmm_front.sv */
// Front part: holds the self key and tags each incoming transaction as self or peer.
// Depends on gmm_pkg.
module gmm_front
    import gmm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_q_push,
    output t_job     o_job
);

    logic [KEY_W-1:0] r_self_key;
    logic [KEY_W-1:0] n_self_key;

    always_comb begin
        n_self_key = r_self_key;
        if (i_cfg.we && i_cfg.idx == CFG_SELF_KEY) begin
            n_self_key = i_cfg.data[KEY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_key <= '0;
        end else begin
            r_self_key <= n_self_key;
        end
    end

    assign o_q_push         = i_push;
    assign o_job.func       = i_item.func;
    assign o_job.member_key = i_item.member_key;
    assign o_job.is_dead    = i_item.is_dead;
    assign o_job.generation = i_item.generation;
    assign o_job.is_self    = (i_item.member_key == r_self_key);

endmodule

/* src/gmm_fifo.sv */
// Short queue of classified jobs between the front and back parts.
// Depends on gmm_pkg.
module gmm_fifo
    import gmm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_job i_data,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_data
);

    t_job                r_slot [JOB_Q_DEPTH];
    logic [JOB_Q_PW-1:0] r_wr_ptr;
    logic [JOB_Q_PW-1:0] r_rd_ptr;
    logic [JOB_Q_PW:0]   r_fill;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_fill == (JOB_Q_PW+1)'(JOB_Q_DEPTH));
    assign o_valid = (r_fill != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == JOB_Q_PW'(JOB_Q_DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == JOB_Q_PW'(JOB_Q_DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

/* src/gmm_back.sv */
// Back part: scans the membership table, merges the job and registers the result.
// Depends on gmm_pkg; holds the table memory, entry count and own generation.
module gmm_back
    import gmm_pkg::*;
#(
    parameter int MAX_MEMBERS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_job_valid,
    output logic      o_job_pop,
    input  t_job      i_job,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_item
);

    localparam int IW  = $clog2(MAX_MEMBERS);
    localparam int CW  = $clog2(MAX_MEMBERS + 1);
    localparam int IWX = (IW > ENTRY_INDEX_W) ? IW : ENTRY_INDEX_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    t_entry          r_mem [MAX_MEMBERS];
    t_entry          r_rd;
    logic [1:0]      r_state, n_state;
    logic [IW-1:0]   r_idx, n_idx;
    logic            r_hit, n_hit;
    t_job            r_job, n_job;
    logic [CW-1:0]   r_count, n_count;
    logic [GEN_W-1:0] r_own, n_own;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out, n_out;

    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    t_entry          wr_data;
    t_entry          new_e;
    t_out_item       res;
    logic [IWX-1:0]  idx_ext;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_job       = r_job;
        n_count     = r_count;
        n_own       = r_own;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        rd_en       = 1'b0;
        rd_addr     = r_idx;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = r_rd;
        new_e       = r_rd;
        res         = '0;
        idx_ext     = '0;
        o_job_pop   = 1'b0;

        if (i_cfg.we && i_cfg.idx == CFG_BOOT_GEN) begin
            n_own = i_cfg.data;
        end

        unique case (r_state)
            S_IDLE: begin
                // Start only with the result slot free so the job can finish unblocked
                if (i_job_valid && !r_out_valid) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_idx     = '0;
                    n_hit     = 1'b0;
                    if (!i_job.is_self && r_count != '0) begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_SCAN: begin
                if (r_rd.key == r_job.member_key) begin
                    n_hit   = 1'b1;
                    n_state = S_EXEC;
                end else if (CW'(r_idx) + CW'(1) == r_count) begin
                    n_hit   = 1'b0;
                    n_state = S_EXEC;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    rd_en   = 1'b1;
                    rd_addr = r_idx + IW'(1);
                end
            end
            S_EXEC: begin
                res.own_generation = r_own;
                if (r_job.is_self) begin
                    if (r_job.func == FUNC_MERGE && r_job.is_dead
                        && r_job.generation >= r_own) begin
                        n_own = (&r_job.generation) ? r_job.generation
                                                    : r_job.generation + GEN_W'(1);
                        res.status         = ST_REFUTED;
                        res.view_changed   = 1'b1;
                        res.own_generation = n_own;
                    end
                end else if (r_hit) begin
                    if (r_job.func == FUNC_MERGE) begin
                        if (r_job.generation > r_rd.generation) begin
                            new_e.generation = r_job.generation;
                            new_e.dead       = r_job.is_dead;
                            if (r_rd.dead != r_job.is_dead) begin
                                res.view_changed = 1'b1;
                                res.status       = r_job.is_dead ? ST_DEAD : ST_REVIVED;
                            end else begin
                                res.status = ST_UPDATED;
                            end
                        end else if (r_job.generation == r_rd.generation
                                     && r_job.is_dead && !r_rd.dead) begin
                            new_e.dead       = 1'b1;
                            res.status       = ST_DEAD;
                            res.view_changed = 1'b1;
                        end
                    end else if (r_rd.dead || r_job.generation > r_rd.generation) begin
                        new_e.dead = 1'b0;
                        if (r_job.generation > r_rd.generation) begin
                            new_e.generation = r_job.generation;
                        end
                        res.status       = r_rd.dead ? ST_REVIVED : ST_UPDATED;
                        res.view_changed = 1'b1;
                    end
                    wr_en                = 1'b1;
                    wr_addr              = r_idx;
                    wr_data              = new_e;
                    idx_ext              = IWX'(r_idx);
                    res.entry_index      = idx_ext[ENTRY_INDEX_W-1:0];
                    res.entry_dead       = new_e.dead;
                    res.entry_generation = new_e.generation;
                end else if (r_count >= CW'(MAX_MEMBERS)) begin
                    res.status = ST_FULL;
                end else begin
                    // Learn the key into the next free slot
                    new_e.key            = r_job.member_key;
                    new_e.generation     = r_job.generation;
                    new_e.dead           = (r_job.func == FUNC_MERGE) ? r_job.is_dead : 1'b0;
                    wr_en                = 1'b1;
                    wr_addr              = r_count[IW-1:0];
                    wr_data              = new_e;
                    n_count              = r_count + CW'(1);
                    idx_ext              = IWX'(r_count[IW-1:0]);
                    res.status           = ST_LEARNED;
                    res.view_changed     = 1'b1;
                    res.entry_index      = idx_ext[ENTRY_INDEX_W-1:0];
                    res.entry_dead       = new_e.dead;
                    res.entry_generation = new_e.generation;
                end
                n_out       = res;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_hit <= n_hit;
        r_job <= n_job;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_own       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_own       <= n_own;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_MEMBERS))
        else $error("entry count beyond table depth");

    a_exec_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |-> !r_out_valid)
        else $error("job finished while result slot occupied");

    a_scan_peer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> (r_count != '0 && !r_job.is_self))
        else $error("table scan on empty table or self job");

    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_FULL) |-> r_count == CW'(MAX_MEMBERS))
        else $error("table full reported with free slots");

    a_learn_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && n_count != r_count)
        |=> (r_out_valid && r_out.status == ST_LEARNED))
        else $error("entry count moved without a learned result");

endmodule
